>>> src/hsv_to_rgb_convert_top_assert.svh
// Assertion macros shared by the checker of the colour converter.
// Clocked on aclk; the first form is switched off while reset is held.
`ifndef HSV_TO_RGB_CONVERT_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERT_TOP_ASSERT_SVH

`define HSVRGB_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("hsv_to_rgb_convert_top: assertion failed");

`define HSVRGB_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("hsv_to_rgb_convert_top: reset assertion failed");

`endif

>>> src/hsvrgb_pkg.sv
package hsvrgb_pkg;

    localparam int unsigned HUE_W    = 9;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned TMID_W   = 6;
    localparam int unsigned SCALE_W  = 15;   // 255 * value
    localparam int unsigned DIFF_W   = 13;   // 6000 - sat * t
    localparam int unsigned PROD_W   = 28;   // scaled value times difference
    localparam int unsigned RECIP_W  = 29;
    localparam int unsigned QPROD_W  = PROD_W + RECIP_W;
    localparam int unsigned RECIP_SH = 48;

    localparam logic [HUE_W-1:0]   HUE_MAX   = 9'd360;
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
    localparam logic [DIFF_W-1:0]  FULL_DIFF = 13'd6000;
    localparam logic [TMID_W-1:0]  T_LOW     = 6'd60;
    // ceil(2^48 / 600000): exact floor division for every product below 2^28.
    localparam logic [RECIP_W-1:0] RECIP     = 29'd469124962;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic               oor;
        sector_t            sector;
        logic [TMID_W-1:0]  tmid;
        logic [PCT_W-1:0]   sat;
        logic [SCALE_W-1:0] vscale;
    } dec_t;

    typedef struct packed {
        logic               oor;
        sector_t            sector;
        logic [SCALE_W-1:0] vscale;
        logic [DIFF_W-1:0]  dmid;
        logic [DIFF_W-1:0]  dlo;
    } diff_t;

    typedef struct packed {
        logic              oor;
        sector_t           sector;
        logic [PROD_W-1:0] phi;
        logic [PROD_W-1:0] pmid;
        logic [PROD_W-1:0] plo;
    } prod_t;

endpackage

>>> src/hsv_to_rgb_convert_top.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_hue[8:0], s_saturation[6:0], s_brightness[6:0]
// m_        out        m_valid / m_ready  m_red, m_green, m_blue [7:0], m_out_of_range
//
// One beat is accepted every clock cycle unless a stall on m_ready has filled
// every stage; each beat passes through the four register stages of the pipeline.
// Reset is synchronous and active low on aresetn; it empties every stage.
// A stall on m_ready holds the output stage, and each earlier stage keeps
// taking beats until it is full, so bubbles are squeezed out during a stall.
module hsv_to_rgb_convert_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  s_hue,
    input  logic [hsvrgb_pkg::PCT_W-1:0]  s_saturation,
    input  logic [hsvrgb_pkg::PCT_W-1:0]  s_brightness,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hsvrgb_pkg::CHAN_W-1:0] m_red,
    output logic [hsvrgb_pkg::CHAN_W-1:0] m_green,
    output logic [hsvrgb_pkg::CHAN_W-1:0] m_blue,
    output logic                          m_out_of_range
);
    import hsvrgb_pkg::*;

    // Between the stages every beat carries its own valid bit, and each stage
    // is ready when it is empty or when the stage after it is ready.
    logic  dec_valid, dec_ready;
    dec_t  dec_data;
    logic  prod_valid, prod_ready;
    prod_t prod_data;

    // Stage one: range check, sector of the hue and the distance of the
    // middle channel from the sector edge, and 255 times the value.
    hsvrgb_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .hue       (s_hue),
        .sat       (s_saturation),
        .val       (s_brightness),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // Stages two and three: the weights for the three channels, then their
    // products with the scaled value.
    hsvrgb_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // Stage four: floor division by 600000 and assignment of the largest,
    // middle and smallest levels to red, green and blue by sector. An input
    // out of range forces all three channels to zero.
    hsvrgb_quot u_quot (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (prod_valid),
        .in_ready     (prod_ready),
        .in_data      (prod_data),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .red          (m_red),
        .green        (m_green),
        .blue         (m_blue),
        .out_of_range (m_out_of_range)
    );

endmodule

>>> src/hsvrgb_decode.sv
module hsvrgb_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  hue,
    input  logic [hsvrgb_pkg::PCT_W-1:0]  sat,
    input  logic [hsvrgb_pkg::PCT_W-1:0]  val,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hsvrgb_pkg::dec_t              out_data
);
    import hsvrgb_pkg::*;

    localparam logic [HUE_W-1:0] HUE_60  = 9'd60;
    localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
    localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
    localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
    localparam logic [HUE_W-1:0] HUE_300 = 9'd300;

    logic       valid_reg;
    dec_t       data_reg;
    dec_t       data_next;
    logic [HUE_W-1:0] rem;
    logic [HUE_W-1:0] tdist;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.oor = (hue > HUE_MAX) || (sat > PCT_MAX) || (val > PCT_MAX);

        if (hue < HUE_60) begin
            data_next.sector = SEC_R_TO_Y;
        end else if (hue < HUE_120) begin
            data_next.sector = SEC_Y_TO_G;
        end else if (hue < HUE_180) begin
            data_next.sector = SEC_G_TO_C;
        end else if (hue < HUE_240) begin
            data_next.sector = SEC_C_TO_B;
        end else if (hue < HUE_300) begin
            data_next.sector = SEC_B_TO_M;
        end else begin
            data_next.sector = SEC_M_TO_R;
        end

        // Hue modulo 120 for hues below 480, by subtracting the largest of 360, 240 and 120 not above it.
        if (hue >= HUE_MAX) begin
            rem = hue - HUE_MAX;
        end else if (hue >= HUE_240) begin
            rem = hue - HUE_240;
        end else if (hue >= HUE_120) begin
            rem = hue - HUE_120;
        end else begin
            rem = hue;
        end

        tdist = (rem >= HUE_60) ? (rem - HUE_60) : (HUE_60 - rem);

        data_next.tmid   = tdist[TMID_W-1:0];
        data_next.sat    = sat;
        data_next.vscale = {val, 8'b0} - SCALE_W'(val);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/hsvrgb_scale.sv
module hsvrgb_scale (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  hsvrgb_pkg::dec_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hsvrgb_pkg::prod_t out_data
);
    import hsvrgb_pkg::*;

    logic  diff_valid_reg;
    diff_t diff_reg;
    diff_t diff_next;
    logic  diff_ready;

    logic  prod_valid_reg;
    prod_t prod_reg;
    prod_t prod_next;

    logic [DIFF_W-1:0] smid;
    logic [DIFF_W-1:0] slo;

    assign diff_ready = !prod_valid_reg || out_ready;
    assign in_ready   = !diff_valid_reg || diff_ready;
    assign out_valid  = prod_valid_reg;
    assign out_data   = prod_reg;

    // First stage: the weight 6000 - sat * t for the middle and smallest channels.
    always_comb begin
        smid = DIFF_W'(in_data.sat) * DIFF_W'(in_data.tmid);
        slo  = DIFF_W'(in_data.sat) * DIFF_W'(T_LOW);
        diff_next.oor    = in_data.oor;
        diff_next.sector = in_data.sector;
        diff_next.vscale = in_data.vscale;
        diff_next.dmid   = FULL_DIFF - smid;
        diff_next.dlo    = FULL_DIFF - slo;
    end

    // Second stage: scale each weight by 255 * value.
    always_comb begin
        prod_next.oor    = diff_reg.oor;
        prod_next.sector = diff_reg.sector;
        prod_next.phi    = PROD_W'(diff_reg.vscale) * PROD_W'(FULL_DIFF);
        prod_next.pmid   = PROD_W'(diff_reg.vscale) * PROD_W'(diff_reg.dmid);
        prod_next.plo    = PROD_W'(diff_reg.vscale) * PROD_W'(diff_reg.dlo);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                diff_valid_reg <= in_valid;
            end
            if (diff_ready) begin
                prod_valid_reg <= diff_valid_reg;
            end
        end
        if (in_ready && in_valid) begin
            diff_reg <= diff_next;
        end
        if (diff_ready && diff_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

endmodule

>>> src/hsvrgb_quot.sv
module hsvrgb_quot (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hsvrgb_pkg::prod_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hsvrgb_pkg::CHAN_W-1:0] red,
    output logic [hsvrgb_pkg::CHAN_W-1:0] green,
    output logic [hsvrgb_pkg::CHAN_W-1:0] blue,
    output logic                          out_of_range
);
    import hsvrgb_pkg::*;

    logic              valid_reg;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;
    logic              oor_reg;
    logic [CHAN_W-1:0] red_next, green_next, blue_next;

    logic [QPROD_W-1:0] qhi, qmid, qlo;
    logic [CHAN_W-1:0]  hi, mid, lo;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign out_of_range = oor_reg;

    always_comb begin
        // Division by 600000 through the reciprocal; the quotient never exceeds 255.
        qhi  = QPROD_W'(in_data.phi)  * QPROD_W'(RECIP);
        qmid = QPROD_W'(in_data.pmid) * QPROD_W'(RECIP);
        qlo  = QPROD_W'(in_data.plo)  * QPROD_W'(RECIP);
        hi   = qhi[RECIP_SH +: CHAN_W];
        mid  = qmid[RECIP_SH +: CHAN_W];
        lo   = qlo[RECIP_SH +: CHAN_W];

        unique case (in_data.sector)
            SEC_R_TO_Y: begin red_next = hi;  green_next = mid; blue_next = lo;  end
            SEC_Y_TO_G: begin red_next = mid; green_next = hi;  blue_next = lo;  end
            SEC_G_TO_C: begin red_next = lo;  green_next = hi;  blue_next = mid; end
            SEC_C_TO_B: begin red_next = lo;  green_next = mid; blue_next = hi;  end
            SEC_B_TO_M: begin red_next = mid; green_next = lo;  blue_next = hi;  end
            default:    begin red_next = hi;  green_next = lo;  blue_next = mid; end
        endcase

        if (in_data.oor) begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            oor_reg   <= in_data.oor;
        end
    end

endmodule

>>> src/hsvrgb_check.sv
`include "hsv_to_rgb_convert_top_assert.svh"

module hsvrgb_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hsvrgb_pkg::CHAN_W-1:0] m_red,
    input logic [hsvrgb_pkg::CHAN_W-1:0] m_green,
    input logic [hsvrgb_pkg::CHAN_W-1:0] m_blue,
    input logic                          m_out_of_range
);

    // A stalled result beat stays, unchanged.
    `HSVRGB_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid)
    `HSVRGB_ASSERT(a_out_stable, m_valid && !m_ready |=> $stable({m_red, m_green, m_blue, m_out_of_range}))

    // A flagged beat carries no colour.
    `HSVRGB_ASSERT(a_oor_black, m_valid && m_out_of_range |-> {m_red, m_green, m_blue} == '0)

    // The input side only refuses a beat when the pipeline is full and the output is stalled.
    `HSVRGB_ASSERT(a_ready_stall, !s_ready |-> m_valid && !m_ready)

    // Reset empties the pipeline.
    `HSVRGB_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid)

endmodule

bind hsv_to_rgb_convert_top hsvrgb_check u_check (.*);

>>> bench/hsv_to_rgb_convert_top_test.sv
`timescale 1ns / 1ps

// Testbench for the HSV to RGB colour converter.
//
// Input beats are driven on the s_ channel. Each accepted beat is passed
// through a behavioural copy of the conversion, and the predicted colour is
// queued. Every result beat taken from the m_ channel is compared, field by
// field, with the oldest colour in that queue. The conversion keeps nothing
// from one beat to the next, so the run simply moves through a few stimulus
// phases:
// - directed corner colours without any idling,
// - random in-range colours with random idling on both channels,
// - random values over the full width of every field, which also covers the
//   out-of-range flag,
// - a final stretch of back-to-back beats with no idling at all.
module hsv_to_rgb_convert_top_test;

    import hsvrgb_pkg::*;

    // One predicted or observed result beat.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              oor;
    } rgb_pixel_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [HUE_W-1:0]    s_hue          = '0;
    logic [PCT_W-1:0]    s_saturation   = '0;
    logic [PCT_W-1:0]    s_brightness   = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [CHAN_W-1:0]   m_red;
    logic [CHAN_W-1:0]   m_green;
    logic [CHAN_W-1:0]   m_blue;
    logic                m_out_of_range;

    // Idling switches for the sending and the receiving side.
    bit                  src_idle_en    = 1'b0;
    bit                  sink_idle_en   = 1'b0;
    int unsigned         stall_left     = 0;
    int unsigned         mismatch_count = 0;

    // Colours predicted for accepted input beats, oldest first.
    rgb_pixel_t          rgb_expected[$];

    hsv_to_rgb_convert_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_hue          (s_hue),
        .s_saturation   (s_saturation),
        .s_brightness   (s_brightness),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_out_of_range (m_out_of_range)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a time limit far beyond the slowest correct run, even with the
    // longest gaps and stalls.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Intensity of one channel: 255 * value scaled down by the share that
    // saturation takes away, with t the channel's distance from the top.
    // The largest product, 255 * 100 * 6000, fits easily in 32 bits.
    function automatic int unsigned channel_level(input int unsigned sat,
                                                  input int unsigned val,
                                                  input int unsigned t);
        return (255 * val * (6000 - sat * t)) / 600000;
    endfunction

    function automatic rgb_pixel_t predict_rgb(input logic [HUE_W-1:0] hue,
                                               input logic [PCT_W-1:0] sat,
                                               input logic [PCT_W-1:0] val);
        rgb_pixel_t  px;
        int unsigned sec_idx;
        int unsigned rem;
        int unsigned tmid;
        int unsigned hi;
        int unsigned lo;
        int unsigned mid;
        sector_t     sec;

        px = '0;
        // Any field beyond its valid range blanks the colour and sets the flag.
        if (hue > HUE_MAX || sat > PCT_MAX || val > PCT_MAX) begin
            px.oor = 1'b1;
            return px;
        end

        // A hue of exactly 360 degrees belongs to the magenta-to-red sector.
        sec_idx = 32'(hue) / 60;
        if (sec_idx > 5) begin
            sec_idx = 5;
        end
        sec = sector_t'(sec_idx[2:0]);

        rem  = 32'(hue) % 120;
        tmid = (rem >= 60) ? rem - 60 : 60 - rem;
        hi   = channel_level(32'(sat), 32'(val), 0);
        lo   = channel_level(32'(sat), 32'(val), 32'(T_LOW));
        mid  = channel_level(32'(sat), 32'(val), tmid);

        case (sec)
            SEC_R_TO_Y: begin
                px.red = hi[7:0];  px.green = mid[7:0]; px.blue = lo[7:0];
            end
            SEC_Y_TO_G: begin
                px.red = mid[7:0]; px.green = hi[7:0];  px.blue = lo[7:0];
            end
            SEC_G_TO_C: begin
                px.red = lo[7:0];  px.green = hi[7:0];  px.blue = mid[7:0];
            end
            SEC_C_TO_B: begin
                px.red = lo[7:0];  px.green = mid[7:0]; px.blue = hi[7:0];
            end
            SEC_B_TO_M: begin
                px.red = mid[7:0]; px.green = lo[7:0];  px.blue = hi[7:0];
            end
            default: begin
                px.red = hi[7:0];  px.green = lo[7:0];  px.blue = mid[7:0];
            end
        endcase
        return px;
    endfunction

    // Sends one beat and records its predicted colour once it is accepted.
    // Valid is left high on return, so that a following beat can go out on
    // the very next edge; it is only lowered when an idle gap is inserted
    // or when the stimulus is over.
    task automatic send_pixel(input logic [HUE_W-1:0] hue,
                              input logic [PCT_W-1:0] sat,
                              input logic [PCT_W-1:0] val);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_brightness <= val;
        // Values read straight after the edge are the ones the block sampled.
        do begin
            @(posedge aclk);
        end while (!s_ready);
        rgb_expected.push_back(predict_rgb(hue, sat, val));
    endtask

    // The six sector boundaries, both ends of every field, the hues where the
    // middle channel meets the top or the bottom one, and the three ways of
    // leaving the valid range.
    task automatic test_corner_colours();
        send_pixel(9'd0,   7'd100, 7'd100);
        send_pixel(9'd59,  7'd100, 7'd100);
        send_pixel(9'd60,  7'd100, 7'd100);
        send_pixel(9'd119, 7'd100, 7'd100);
        send_pixel(9'd120, 7'd100, 7'd100);
        send_pixel(9'd180, 7'd100, 7'd100);
        send_pixel(9'd239, 7'd100, 7'd100);
        send_pixel(9'd240, 7'd100, 7'd100);
        send_pixel(9'd300, 7'd100, 7'd100);
        send_pixel(9'd359, 7'd100, 7'd100);
        send_pixel(9'd360, 7'd100, 7'd100);
        send_pixel(9'd360, 7'd50,  7'd77);
        send_pixel(9'd30,  7'd0,   7'd100);
        send_pixel(9'd210, 7'd100, 7'd0);
        send_pixel(9'd0,   7'd0,   7'd0);
        send_pixel(9'd90,  7'd50,  7'd50);
        send_pixel(9'd361, 7'd50,  7'd50);
        send_pixel(9'd511, 7'd0,   7'd0);
        send_pixel(9'd100, 7'd101, 7'd50);
        send_pixel(9'd100, 7'd127, 7'd50);
        send_pixel(9'd100, 7'd50,  7'd101);
        send_pixel(9'd100, 7'd50,  7'd127);
        send_pixel(9'd511, 7'd127, 7'd127);
    endtask

    // Well-formed colours, where all of the arithmetic is exercised.
    task automatic test_random_in_range(input int unsigned count);
        repeat (count) begin
            send_pixel(HUE_W'($urandom_range(0, 360)), PCT_W'($urandom_range(0, 100)),
                       PCT_W'($urandom_range(0, 100)));
        end
    endtask

    // Every field over its full width, so that every input bit toggles and a
    // good share of beats carries the out-of-range flag.
    task automatic test_random_full_range(input int unsigned count);
        repeat (count) begin
            send_pixel(HUE_W'($urandom_range(0, 511)), PCT_W'($urandom_range(0, 127)),
                       PCT_W'($urandom_range(0, 127)));
        end
    endtask

    // Mostly valid colours at full rate, with the odd out-of-range beat.
    task automatic test_back_to_back(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 7) == 0) begin
                send_pixel(HUE_W'($urandom_range(0, 511)), PCT_W'($urandom_range(0, 127)),
                           PCT_W'($urandom_range(0, 127)));
            end else begin
                send_pixel(HUE_W'($urandom_range(0, 360)), PCT_W'($urandom_range(0, 100)),
                           PCT_W'($urandom_range(0, 100)));
            end
        end
    endtask

    // Receiver: stalls come in bursts of random length while idling is
    // enabled, otherwise ready is held high.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_ready    <= 1'b0;
        end else begin
            m_ready    <= 1'b1;
        end
    end

    // Result checker: each accepted result beat is matched against the oldest
    // predicted colour. Only the first ten mismatches are described.
    always @(posedge aclk) begin
        rgb_pixel_t got;
        rgb_pixel_t want;

        if (aresetn && m_valid && m_ready) begin
            got = '{m_red, m_green, m_blue, m_out_of_range};
            if (rgb_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result beat with nothing expected: r=%0d g=%0d b=%0d oor=%0b",
                             $realtime, got.red, got.green, got.blue, got.oor);
                end
            end else begin
                want = rgb_expected.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.oor !== want.oor) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: wanted r=%0d g=%0d b=%0d oor=%0b, got r=%0d g=%0d b=%0d oor=%0b",
                                 $realtime, want.red, want.green, want.blue, want.oor,
                                 got.red, got.green, got.blue, got.oor);
                    end
                end
            end
        end
    end

    initial begin
        // Reset is held at the start of the run and never again.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_colours();

        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_random_in_range(320);
        test_random_full_range(120);

        // The last part of the run goes at full rate on both sides.
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_back_to_back(60);
        s_valid <= 1'b0;

        // Drain the pipeline, then allow a few cycles for any stray beat.
        while (rgb_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
